[hdl/assert_macros.svh]
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MJW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define MJW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/mjw_pkg.sv]
// types, codes and arithmetic helpers of the midi jog wheel decoder
package mjw_pkg;

  localparam int ACC_WIDTH = 24;
  localparam int JOG_W     = 24;
  localparam int DELTA_W   = 9;
  localparam int EXT_W     = (ACC_WIDTH > JOG_W) ? ACC_WIDTH : JOG_W;

  // command codes
  localparam logic [2:0] MODE_MIDI        = 3'd0;
  localparam logic [2:0] MODE_CONSUME     = 3'd1;
  localparam logic [2:0] MODE_LEARN_JOG   = 3'd2;
  localparam logic [2:0] MODE_LEARN_TOUCH = 3'd3;
  localparam logic [2:0] MODE_CANCEL      = 3'd4;
  localparam logic [2:0] MODE_SET_JOG     = 3'd5;
  localparam logic [2:0] MODE_SET_TOUCH   = 3'd6;

  // learn target and learned event codes
  localparam logic [1:0] LEARN_NONE  = 2'd0;
  localparam logic [1:0] LEARN_JOG   = 2'd1;
  localparam logic [1:0] LEARN_TOUCH = 2'd2;

  // midi message types (status high nibble)
  localparam logic [3:0] MSG_CC       = 4'hB;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;

  localparam logic [6:0] CENTRE    = 7'd64;
  localparam logic [6:0] BAND_LO   = 7'd32;  // centre minus band
  localparam logic [6:0] BAND_HI   = 7'd96;  // centre plus band

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } in_t;

  typedef struct packed {
    logic signed [JOG_W-1:0] jog_delta;
    logic                    touch_active;
    logic [1:0]              learn_state;
    logic [1:0]              learned_event;
    logic                    relative_active;
    logic                    jog_mapped;
    logic                    touch_mapped;
  } out_t;

  typedef struct packed {
    logic [1:0]                  learn_target;
    logic [3:0]                  jog_ch;
    logic [6:0]                  jog_num;
    logic                        jog_valid;
    logic [3:0]                  touch_ch;
    logic [6:0]                  touch_num;
    logic                        touch_valid;
    logic                        rel_flag;
    logic [6:0]                  last_abs;
    logic                        last_abs_valid;
    logic signed [ACC_WIDTH-1:0] acc;
    logic                        touch_flag;
  } state_t;

  // decoder state after reset: unmapped, not learning, relative decoding on
  localparam state_t ST_RESET = '{
    learn_target:   LEARN_NONE,
    jog_ch:         4'd0,
    jog_num:        7'd0,
    jog_valid:      1'b0,
    touch_ch:       4'd0,
    touch_num:      7'd0,
    touch_valid:    1'b0,
    rel_flag:       1'b1,
    last_abs:       7'd0,
    last_abs_valid: 1'b0,
    acc:            '0,
    touch_flag:     1'b0
  };

  // saturating add of a small signed delta into the accumulator
  function automatic logic signed [ACC_WIDTH-1:0] acc_sat_add(
    input logic signed [ACC_WIDTH-1:0] a,
    input logic signed [DELTA_W-1:0]   d
  );
    logic signed [ACC_WIDTH:0] s;
    logic signed [ACC_WIDTH-1:0] r;
    s = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(d);
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      r = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      r = s[ACC_WIDTH-1:0];
    end
    return r;
  endfunction

  // clamp the accumulator to the output delta range
  function automatic logic signed [JOG_W-1:0] out_sat(input logic signed [ACC_WIDTH-1:0] a);
    logic signed [EXT_W-1:0] e;
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    logic signed [JOG_W-1:0] r;
    e  = EXT_W'(a);
    hi = EXT_W'({1'b0, {(JOG_W-1){1'b1}}});
    lo = -hi - EXT_W'(1);
    if (e > hi) begin
      r = {1'b0, {(JOG_W-1){1'b1}}};
    end else if (e < lo) begin
      r = {1'b1, {(JOG_W-1){1'b0}}};
    end else begin
      r = e[JOG_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/mjw_step.sv]
// next-state and result logic for one command
module mjw_step (
  input  mjw_pkg::state_t st,
  input  mjw_pkg::in_t    item,
  output mjw_pkg::state_t st_nxt,
  output mjw_pkg::out_t   res
);
  import mjw_pkg::*;

  logic [3:0]                msg_type;
  logic [3:0]                ch;
  logic                      is_cc;
  logic                      is_note;
  logic                      jog_hit;
  logic                      touch_hit;
  logic                      add_en;
  logic signed [DELTA_W-1:0] delta;
  logic signed [DELTA_W-1:0] diff;
  logic [1:0]                learned;

  assign msg_type  = item.status_byte[7:4];
  assign ch        = item.status_byte[3:0];
  assign is_cc     = (msg_type == MSG_CC);
  assign is_note   = (msg_type == MSG_NOTE_ON) || (msg_type == MSG_NOTE_OFF);
  assign jog_hit   = is_cc && st.jog_valid && (ch == st.jog_ch) && (item.data_one == st.jog_num);
  assign touch_hit = is_note && st.touch_valid && (ch == st.touch_ch)
                     && (item.data_one == st.touch_num);

  // wrapped difference from the previous absolute value
  always_comb begin
    diff = $signed({2'b00, item.data_two}) - $signed({2'b00, st.last_abs});
    if (diff > $signed(9'sd64)) begin
      diff = diff - $signed(9'sd128);
    end else if (diff < -$signed(9'sd64)) begin
      diff = diff + $signed(9'sd128);
    end
  end

  always_comb begin
    st_nxt  = st;
    learned = LEARN_NONE;
    add_en  = 1'b0;
    delta   = '0;
    res     = '0;
    case (item.mode)
      MODE_MIDI: begin
        if (st.learn_target != LEARN_NONE) begin
          if (st.learn_target == LEARN_JOG && is_cc) begin
            st_nxt.jog_ch         = ch;
            st_nxt.jog_num        = item.data_one;
            st_nxt.jog_valid      = 1'b1;
            st_nxt.last_abs_valid = 1'b0;
            st_nxt.rel_flag       = 1'b1;
            st_nxt.learn_target   = LEARN_NONE;
            learned               = LEARN_JOG;
          end else if (st.learn_target == LEARN_TOUCH && is_note) begin
            st_nxt.touch_ch     = ch;
            st_nxt.touch_num    = item.data_one;
            st_nxt.touch_valid  = 1'b1;
            st_nxt.learn_target = LEARN_NONE;
            learned             = LEARN_TOUCH;
          end
        end else if (jog_hit) begin
          if (st.rel_flag && item.data_two >= BAND_LO && item.data_two <= BAND_HI) begin
            add_en = 1'b1;
            delta  = $signed({2'b00, item.data_two}) - $signed({2'b00, CENTRE});
          end else begin
            st_nxt.rel_flag       = 1'b0;
            add_en                = st.last_abs_valid;
            delta                 = diff;
            st_nxt.last_abs       = item.data_two;
            st_nxt.last_abs_valid = 1'b1;
          end
        end else if (touch_hit) begin
          st_nxt.touch_flag = (msg_type == MSG_NOTE_ON) && (item.data_two != 7'd0);
        end
      end
      MODE_CONSUME: begin
        res.jog_delta = out_sat(st.acc);
        st_nxt.acc    = '0;
      end
      MODE_LEARN_JOG:   st_nxt.learn_target = LEARN_JOG;
      MODE_LEARN_TOUCH: st_nxt.learn_target = LEARN_TOUCH;
      MODE_CANCEL:      st_nxt.learn_target = LEARN_NONE;
      MODE_SET_JOG: begin
        st_nxt.jog_ch         = ch;
        st_nxt.jog_num        = item.data_one;
        st_nxt.jog_valid      = 1'b1;
        st_nxt.last_abs_valid = 1'b0;
        st_nxt.rel_flag       = 1'b1;
      end
      MODE_SET_TOUCH: begin
        st_nxt.touch_ch    = ch;
        st_nxt.touch_num   = item.data_one;
        st_nxt.touch_valid = 1'b1;
      end
      default: ;
    endcase

    if (add_en) begin
      st_nxt.acc = acc_sat_add(st.acc, delta);
    end

    res.touch_active    = st_nxt.touch_flag;
    res.learn_state     = st_nxt.learn_target;
    res.learned_event   = learned;
    res.relative_active = st_nxt.rel_flag;
    res.jog_mapped      = st_nxt.jog_valid;
    res.touch_mapped    = st_nxt.touch_valid;
  end

endmodule

[hdl/midi_jog_wheel_decoder_unit.sv]
// top level of the midi jog wheel decoder: input register, step logic, result register
// a command passes through the input reg, then the step logic and the result reg
// throughput: one command per cycle unless the result side stalls; mjw_step is combinational
// backpressure on the result side stalls the result reg, and the input reg once it holds one item
// reset (rst_n low, synchronous): both stages empty, maps cleared, relative decoding on,
// accumulator and touch flag zero, not learning
module midi_jog_wheel_decoder_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mjw_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mjw_pkg::out_t  out_data
);
  import mjw_pkg::*;

  `include "assert_macros.svh"

  // input stage
  logic   in_valid_r;
  in_t    in_data_r;

  // decoder state and result stage
  state_t st_r;
  state_t st_nxt;
  out_t   res;
  logic   out_valid_r;
  out_t   out_data_r;

  // the result stage can take a new transaction when empty or being drained
  logic advance;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // all command work happens here, reading the current state
  mjw_step u_step (
    .st     (st_r),
    .item   (in_data_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= ST_RESET;
    end else begin
      // capture a new command whenever the input reg frees up
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      // move the held command through the step logic into the result reg
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          st_r <= st_nxt;
        end
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_data_r <= in_data;
    end
    if (advance && in_valid_r) begin
      out_data_r <= res;
    end
  end

  // a learned mapping always ends learning
  `MJW_ASSERT_IMPL(a_learn_ends, out_valid && out_data.learned_event != LEARN_NONE, out_data.learn_state == LEARN_NONE)

  // learning a jog map leaves it mapped and back in relative decoding
  `MJW_ASSERT_IMPL(a_jog_learned, out_valid && out_data.learned_event == LEARN_JOG, out_data.jog_mapped && out_data.relative_active)

  // learning a touch map leaves it mapped
  `MJW_ASSERT_IMPL(a_touch_learned, out_valid && out_data.learned_event == LEARN_TOUCH, out_data.touch_mapped)

  // an empty pipeline never refuses an input transaction
  `MJW_ASSERT_IMPL(a_ready_empty, !out_valid_r && !in_valid_r, in_ready)

  // a held input item reaches the result reg once the output drains
  `MJW_ASSERT_NEXT(a_item_moves, in_valid_r && advance, out_valid_r)

endmodule

[sim/tb_midi_jog_wheel_decoder_unit.sv]
// self-checking testbench for the midi jog wheel decoder unit
module tb_midi_jog_wheel_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mjw_pkg::*;

  // wheel arithmetic as plain signed ints so no compare goes unsigned
  localparam int WHEEL_MID  = int'(CENTRE);
  localparam int WHEEL_LO   = int'(BAND_LO);
  localparam int WHEEL_HI   = int'(BAND_HI);
  localparam int WHEEL_SPAN = 128;

  // mode code the decoder does not know
  localparam logic [2:0] MODE_UNKNOWN = 3'd7;

  // idle percentages change after PHASE_LEN and after 2 * PHASE_LEN accepted transactions
  localparam int PHASE_LEN    = 650;
  localparam int RANDOM_ITEMS = 1760;
  // absolute-mode turns of nearly half a revolution per value, one run each way
  localparam int SPIN_STEPS   = 90;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int PRINT_LIMIT  = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  midi_jog_wheel_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // commands waiting for the driver, and decoder results still owed by the dut
  in_t  cmd_q[$];
  out_t owed_q[$];
  int   n_accepted = 0;
  int   errors = 0;
  int   cycle_count = 0;

  // ---------------------------------------------------------------------------
  // decoder shadow state, starting at the reset values
  // ---------------------------------------------------------------------------
  logic [1:0]                  learning = LEARN_NONE;
  logic [3:0]                  jog_chan = '0;
  logic [6:0]                  jog_num = '0;
  logic                        jog_on = 1'b0;
  logic [3:0]                  touch_chan = '0;
  logic [6:0]                  touch_num = '0;
  logic                        touch_on = 1'b0;
  logic                        wheel_relative = 1'b1;
  logic [6:0]                  prev_pos = '0;
  logic                        prev_pos_ok = 1'b0;
  logic signed [ACC_WIDTH-1:0] jog_sum = '0;
  logic                        held = 1'b0;

  // saturating add into the jog sum
  function automatic void bump_sum(input int d);
    longint s;
    longint top;
    top = (longint'(1) << (ACC_WIDTH - 1)) - 1;
    s = longint'(jog_sum) + longint'(d);
    if (s > top) s = top;
    if (s < -top - 1) s = -top - 1;
    jog_sum = s[ACC_WIDTH-1:0];
  endfunction

  // a new jog mapping also restarts relative decoding
  function automatic void map_jog(input logic [3:0] ch, input logic [6:0] num);
    jog_chan = ch;
    jog_num = num;
    jog_on = 1'b1;
    prev_pos_ok = 1'b0;
    wheel_relative = 1'b1;
  endfunction

  function automatic void map_touch(input logic [3:0] ch, input logic [6:0] num);
    touch_chan = ch;
    touch_num = num;
    touch_on = 1'b1;
  endfunction

  // one command in, the decoder result it produces
  function automatic out_t decode_command(input in_t c);
    out_t       r;
    logic [3:0] kind;
    logic [3:0] chan;
    logic       is_cc;
    logic       is_note;
    int         pos;
    int         moved;
    logic       used;
    longint     e;
    longint     top;
    r = '0;
    kind = c.status_byte[7:4];
    chan = c.status_byte[3:0];
    is_cc = (kind == MSG_CC);
    is_note = (kind == MSG_NOTE_ON) || (kind == MSG_NOTE_OFF);
    case (c.mode)
      MODE_MIDI: begin
        if (learning != LEARN_NONE) begin
          // while learning, only a message of the wanted kind does anything
          if (learning == LEARN_JOG && is_cc) begin
            map_jog(chan, c.data_one);
            learning = LEARN_NONE;
            r.learned_event = LEARN_JOG;
          end else if (learning == LEARN_TOUCH && is_note) begin
            map_touch(chan, c.data_one);
            learning = LEARN_NONE;
            r.learned_event = LEARN_TOUCH;
          end
        end else if (is_cc && jog_on && chan == jog_chan && c.data_one == jog_num) begin
          pos = int'(c.data_two);
          used = 1'b0;
          if (wheel_relative) begin
            if (pos >= WHEEL_LO && pos <= WHEEL_HI) begin
              bump_sum(pos - WHEEL_MID);
              used = 1'b1;
            end else begin
              wheel_relative = 1'b0;
            end
          end
          if (!used) begin
            // absolute tracking, shortest way round the 0..127 circle
            if (prev_pos_ok) begin
              moved = pos - int'(prev_pos);
              if (moved > WHEEL_MID) moved -= WHEEL_SPAN;
              if (moved < -WHEEL_MID) moved += WHEEL_SPAN;
              bump_sum(moved);
            end
            prev_pos = c.data_two;
            prev_pos_ok = 1'b1;
          end
        end else if (is_note && touch_on && chan == touch_chan && c.data_one == touch_num) begin
          held = (kind == MSG_NOTE_ON) && (c.data_two != '0);
        end
      end
      MODE_CONSUME: begin
        top = (longint'(1) << (JOG_W - 1)) - 1;
        e = longint'(jog_sum);
        if (e > top) e = top;
        if (e < -top - 1) e = -top - 1;
        r.jog_delta = e[JOG_W-1:0];
        jog_sum = '0;
      end
      MODE_LEARN_JOG:   learning = LEARN_JOG;
      MODE_LEARN_TOUCH: learning = LEARN_TOUCH;
      MODE_CANCEL:      learning = LEARN_NONE;
      MODE_SET_JOG:     map_jog(chan, c.data_one);
      MODE_SET_TOUCH:   map_touch(chan, c.data_one);
      default: ;
    endcase
    r.touch_active = held;
    r.learn_state = learning;
    r.relative_active = wheel_relative;
    r.jog_mapped = jog_on;
    r.touch_mapped = touch_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers; the gen_* maps follow what the command stream has set up
  // ---------------------------------------------------------------------------
  logic [3:0] gen_jog_chan = '0;
  logic [6:0] gen_jog_num = '0;
  logic [3:0] gen_touch_chan = '0;
  logic [6:0] gen_touch_num = '0;

  function automatic void push_cmd(input logic [2:0] m, input logic [7:0] s,
                                   input logic [6:0] a, input logic [6:0] b);
    in_t c;
    c.mode = m;
    c.status_byte = s;
    c.data_one = a;
    c.data_two = b;
    cmd_q.push_back(c);
  endfunction

  // remap the wheel, leave relative mode with a value of 0, then turn by a
  // fixed step in absolute mode for SPIN_STEPS values and consume the sum
  function automatic void spin_wheel(input int step);
    int pos;
    pos = 0;
    push_cmd(MODE_SET_JOG, {4'h0, gen_jog_chan}, gen_jog_num, 7'd0);
    push_cmd(MODE_MIDI, {MSG_CC, gen_jog_chan}, gen_jog_num, 7'd0);
    for (int i = 0; i < SPIN_STEPS; i++) begin
      pos = (pos + step) % WHEEL_SPAN;
      push_cmd(MODE_MIDI, {MSG_CC, gen_jog_chan}, gen_jog_num, 7'(pos));
    end
    push_cmd(MODE_CONSUME, 8'h00, 7'd0, 7'd0);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one pending command per transaction, idles at random by phase
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic fire;
    int   idle_pct;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        // predict at acceptance, in transaction order
        owed_q.push_back(decode_command(in_data));
        n_accepted++;
      end
      idle_pct = (n_accepted < PHASE_LEN) ? 37 : (n_accepted < 2 * PHASE_LEN) ? 84 : 0;
      // payload may only change once the current transaction has gone
      if (fire || !in_valid) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data <= cmd_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    int   stall_pct;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, jog_delta",
                          longint'(out_data.jog_delta), 0);
        end else begin
          want = owed_q.pop_front();
          if (out_data.jog_delta !== want.jog_delta)
            report_mismatch("jog_delta", longint'(out_data.jog_delta), longint'(want.jog_delta));
          if (out_data.touch_active !== want.touch_active)
            report_mismatch("touch_active", out_data.touch_active, want.touch_active);
          if (out_data.learn_state !== want.learn_state)
            report_mismatch("learn_state", out_data.learn_state, want.learn_state);
          if (out_data.learned_event !== want.learned_event)
            report_mismatch("learned_event", out_data.learned_event, want.learned_event);
          if (out_data.relative_active !== want.relative_active)
            report_mismatch("relative_active", out_data.relative_active,
                            want.relative_active);
          if (out_data.jog_mapped !== want.jog_mapped)
            report_mismatch("jog_mapped", out_data.jog_mapped, want.jog_mapped);
          if (out_data.touch_mapped !== want.touch_mapped)
            report_mismatch("touch_mapped", out_data.touch_mapped, want.touch_mapped);
        end
      end
      // receiver stalls heavily first, lightly next, then never
      stall_pct = (n_accepted < PHASE_LEN) ? 84 : (n_accepted < 2 * PHASE_LEN) ? 37 : 0;
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("midi_jog_wheel_decoder_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // command stream, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int         pick;
    int         noise_n;
    logic [3:0] nib;
    logic [3:0] ch;
    logic [6:0] num;
    logic [6:0] val;

    // directed part
    push_cmd(MODE_UNKNOWN, 8'hFF, 7'h7F, 7'h7F);                 // unknown mode
    push_cmd(MODE_MIDI, {MSG_CC, 4'h0}, 7'd0, 7'd127);           // cc with no jog map
    push_cmd(MODE_MIDI, {MSG_NOTE_ON, 4'h0}, 7'd0, 7'd127);      // note with no touch map
    push_cmd(MODE_MIDI, 8'hF0, 7'd0, 7'd0);                      // other message type
    push_cmd(MODE_LEARN_JOG, 8'h00, 7'd0, 7'd0);
    push_cmd(MODE_MIDI, {MSG_NOTE_ON, 4'h3}, 7'd9, 7'd100);      // ignored while learning jog
    push_cmd(MODE_MIDI, 8'hE5, 7'd1, 7'd2);                      // ignored while learning
    push_cmd(MODE_MIDI, {MSG_CC, 4'hF}, 7'd127, 7'd0);           // learns jog 15/127
    push_cmd(MODE_MIDI, {MSG_CC, 4'hF}, 7'd127, 7'd96);          // relative, top of band
    push_cmd(MODE_MIDI, {MSG_CC, 4'hF}, 7'd127, 7'd32);          // relative, bottom of band
    push_cmd(MODE_MIDI, {MSG_CC, 4'hF}, 7'd127, 7'd127);         // leaves the band
    push_cmd(MODE_MIDI, {MSG_CC, 4'hF}, 7'd127, 7'd0);           // wraps forward by one
    push_cmd(MODE_MIDI, {MSG_CC, 4'hF}, 7'd127, 7'd64);          // half turn, no wrap
    push_cmd(MODE_MIDI, {MSG_CC, 4'hF}, 7'd127, 7'd0);           // half turn back
    push_cmd(MODE_CONSUME, 8'h00, 7'd0, 7'd0);
    push_cmd(MODE_LEARN_TOUCH, 8'h00, 7'd0, 7'd0);
    push_cmd(MODE_MIDI, {MSG_CC, 4'hF}, 7'd127, 7'd40);          // cc ignored while learning touch
    push_cmd(MODE_MIDI, {MSG_NOTE_OFF, 4'hF}, 7'd127, 7'd127);   // learns touch on the jog address
    push_cmd(MODE_MIDI, {MSG_NOTE_ON, 4'hF}, 7'd127, 7'd1);      // touch on
    push_cmd(MODE_MIDI, {MSG_CC, 4'hF}, 7'd127, 7'd64);          // cc goes to jog, not touch
    push_cmd(MODE_MIDI, {MSG_NOTE_ON, 4'hF}, 7'd127, 7'd0);      // zero velocity releases
    push_cmd(MODE_MIDI, {MSG_NOTE_ON, 4'hF}, 7'd127, 7'd127);
    push_cmd(MODE_MIDI, {MSG_NOTE_OFF, 4'hF}, 7'd127, 7'd127);
    push_cmd(MODE_LEARN_JOG, 8'h00, 7'd0, 7'd0);
    push_cmd(MODE_CANCEL, 8'h00, 7'd0, 7'd0);
    push_cmd(MODE_SET_TOUCH, 8'h00, 7'd0, 7'd0);
    push_cmd(MODE_SET_JOG, 8'h0A, 7'd5, 7'd0);                   // back to relative
    push_cmd(MODE_CONSUME, 8'h00, 7'd0, 7'd0);
    gen_jog_chan = 4'hA;
    gen_jog_num = 7'd5;
    gen_touch_chan = 4'h0;
    gen_touch_num = 7'd0;

    // random part: mostly wheel and touch traffic on the live maps
    while (cmd_q.size() < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(99) < 75) val = 7'($urandom_range(WHEEL_HI, WHEEL_LO));
        else val = 7'($urandom_range(127));
        push_cmd(MODE_MIDI, {MSG_CC, gen_jog_chan}, gen_jog_num, val);
      end else if (pick < 60) begin
        nib = $urandom_range(1) ? MSG_NOTE_ON : MSG_NOTE_OFF;
        val = ($urandom_range(99) < 20) ? 7'd0 : 7'($urandom_range(127));
        push_cmd(MODE_MIDI, {nib, gen_touch_chan}, gen_touch_num, val);
      end else if (pick < 68) begin
        push_cmd(MODE_CONSUME, 8'($urandom), 7'($urandom), 7'($urandom));
      end else if (pick < 74) begin
        // jog learning, with messages of the wrong kind mixed in
        push_cmd(MODE_LEARN_JOG, 8'($urandom), 7'($urandom), 7'($urandom));
        noise_n = $urandom_range(2);
        for (int i = 0; i < noise_n; i++) begin
          nib = 4'($urandom_range(15));
          if (nib == MSG_CC) nib = MSG_NOTE_ON;
          push_cmd(MODE_MIDI, {nib, gen_touch_chan}, gen_touch_num, 7'($urandom));
        end
        if ($urandom_range(99) < 85) begin
          ch = 4'($urandom);
          num = 7'($urandom);
          push_cmd(MODE_MIDI, {MSG_CC, ch}, num, 7'($urandom));
          gen_jog_chan = ch;
          gen_jog_num = num;
        end else begin
          push_cmd(MODE_CANCEL, 8'($urandom), 7'($urandom), 7'($urandom));
        end
      end else if (pick < 80) begin
        // touch learning, a cc on the jog map must not move the wheel meanwhile
        push_cmd(MODE_LEARN_TOUCH, 8'($urandom), 7'($urandom), 7'($urandom));
        noise_n = $urandom_range(2);
        for (int i = 0; i < noise_n; i++) begin
          if ($urandom_range(1)) begin
            push_cmd(MODE_MIDI, {MSG_CC, gen_jog_chan}, gen_jog_num, 7'($urandom));
          end else begin
            nib = 4'($urandom_range(15));
            if (nib == MSG_NOTE_ON || nib == MSG_NOTE_OFF) nib = MSG_CC;
            push_cmd(MODE_MIDI, {nib, 4'($urandom)}, 7'($urandom), 7'($urandom));
          end
        end
        if ($urandom_range(99) < 85) begin
          ch = 4'($urandom);
          num = 7'($urandom);
          nib = $urandom_range(1) ? MSG_NOTE_ON : MSG_NOTE_OFF;
          push_cmd(MODE_MIDI, {nib, ch}, num, 7'($urandom));
          gen_touch_chan = ch;
          gen_touch_num = num;
        end else begin
          push_cmd(MODE_CANCEL, 8'($urandom), 7'($urandom), 7'($urandom));
        end
      end else if (pick < 85) begin
        // half of the time just re-arm relative decoding on the same map
        if ($urandom_range(1)) begin
          gen_jog_chan = 4'($urandom);
          gen_jog_num = 7'($urandom);
        end
        push_cmd(MODE_SET_JOG, {4'($urandom), gen_jog_chan}, gen_jog_num, 7'($urandom));
      end else if (pick < 89) begin
        // sometimes stack touch on the jog address, so cc and note messages share one address
        if ($urandom_range(99) < 30) begin
          gen_touch_chan = gen_jog_chan;
          gen_touch_num = gen_jog_num;
        end else begin
          gen_touch_chan = 4'($urandom);
          gen_touch_num = 7'($urandom);
        end
        push_cmd(MODE_SET_TOUCH, {4'($urandom), gen_touch_chan}, gen_touch_num,
                 7'($urandom));
      end else begin
        // noise over every field, never starting a learn
        case ($urandom_range(3))
          0:       push_cmd(MODE_MIDI, 8'($urandom), 7'($urandom), 7'($urandom));
          1:       push_cmd(MODE_CONSUME, 8'($urandom), 7'($urandom), 7'($urandom));
          2:       push_cmd(MODE_CANCEL, 8'($urandom), 7'($urandom), 7'($urandom));
          default: push_cmd(MODE_UNKNOWN, 8'($urandom), 7'($urandom), 7'($urandom));
        endcase
      end
    end

    // long absolute-mode turns in both directions, in the no-idle phase
    spin_wheel(63);
    spin_wheel(65);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // sample away from the active edge so driver and monitor updates have settled
    while (cmd_q.size() != 0 || in_valid || owed_q.size() != 0) @(negedge clk);
    // give a stray extra result time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("midi_jog_wheel_decoder_unit: match");
    end else begin
      $display("midi_jog_wheel_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule
